// File: rtl/dts_pkg.sv
// Shared constants and types for the delimited token scanner.
// Used by the top level; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package dts_pkg;

    localparam logic [7:0] CH_BACKSLASH = 8'd92;
    localparam logic [7:0] CH_ESC       = 8'd27;
    localparam logic [7:0] CH_CR        = 8'd13;
    localparam logic [7:0] CH_LF        = 8'd10;
    localparam logic [7:0] CH_SPACE     = 8'd32;
    localparam logic [7:0] CH_QUOTE     = 8'd34;
    localparam logic [7:0] CH_N         = 8'd110;
    localparam logic [7:0] CH_R         = 8'd114;
    localparam logic [7:0] CH_CARET     = 8'd94;

    localparam logic [7:0] DELIMITER_RESET = CH_SPACE;
    localparam logic       ESCAPES_RESET   = 1'b1;

    typedef enum logic [1:0] {
        CAUSE_DELIMITER = 2'd0,
        CAUSE_LINE_END  = 2'd1,
        CAUSE_SOURCE    = 2'd2
    } end_cause_t;

    typedef enum logic [0:0] {
        REG_DELIMITER = 1'b0,
        REG_ESCAPES   = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       token_last;
        end_cause_t end_cause;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/delimited_token_scanner_top.sv
// Top level of the delimited token scanner: escape decoding, token end
// detection, output register and APB register file. Depends on dts_pkg.
`timescale 1ns / 1ps
`default_nettype none

//  Channel  Direction  Accepted when           Payload
//  s_       in         s_tvalid & s_tready     tdata in_byte, tuser source_end
//  m_       out        m_tvalid & m_tready     tdata out_byte, tuser has_byte/cause
//  APB      in         psel & penable & pwrite delimiter at 0, escapes at 4
//
// One item per cycle while the input is ready; each item is decoded in the cycle it is
// accepted and its result, if any, sits in the output register from the next cycle on.
// The input is ready whenever the output register is empty or being taken.
// Reset is synchronous and active low; it restores the register defaults and
// clears a pending escape.

module delimited_token_scanner_top
    import dts_pkg::*;
(
    input  wire        aclk,
    input  wire        aresetn,

    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire  [7:0] s_tdata,   // [7:0] in_byte
    input  wire  [0:0] s_tuser,   // [0] source_end

    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,
    output logic [2:0] m_tuser,   // [0] has_byte, [2:1] end_cause

    input  wire        psel,
    input  wire        penable,
    input  wire        pwrite,
    input  wire  [2:0] paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic       pready
);

    logic [7:0] delimiter_reg;
    logic       escapes_enabled_reg;
    logic       escape_pending_reg;
    logic       escape_pending_next;
    logic       m_valid_reg;
    result_t    result_reg;
    result_t    result_next;
    logic       result_hit;
    logic       in_accept;
    logic       cfg_write;
    reg_index_t cfg_index;

    logic [7:0] c;
    logic [7:0] plain_byte;
    logic [7:0] decoded;
    logic       decode_hit;
    logic       line_delim;
    logic       is_line;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign cfg_index = reg_index_t'(paddr[2]);

    always_comb begin
        unique case (cfg_index)
            REG_DELIMITER: prdata = {24'd0, delimiter_reg};
            REG_ESCAPES:   prdata = {31'd0, escapes_enabled_reg};
            default:       prdata = 32'd0;
        endcase
    end

    assign s_tready  = ~m_valid_reg | m_tready;
    assign in_accept = s_tvalid & s_tready;

    assign c = s_tdata;

    always_comb begin
        decode_hit = 1'b1;
        case (c)
            CH_N:     decoded = CH_LF;
            CH_R:     decoded = CH_CR;
            CH_QUOTE: decoded = CH_QUOTE;
            CH_CARET: decoded = CH_ESC;
            default: begin
                decoded    = 8'd0;
                decode_hit = 1'b0;
            end
        endcase
    end

    assign line_delim = (delimiter_reg == CH_LF) || (delimiter_reg == CH_SPACE);
    assign is_line    = (c == CH_LF) || (c == CH_CR);
    assign plain_byte = c;

    always_comb begin
        result_next         = '{out_byte: 8'd0, has_byte: 1'b0, token_last: 1'b0,
                                end_cause: CAUSE_DELIMITER};
        result_hit          = 1'b0;
        escape_pending_next = escape_pending_reg;
        if (s_tuser[0]) begin
            escape_pending_next    = 1'b0;
            result_hit             = 1'b1;
            result_next.token_last = 1'b1;
            result_next.end_cause  = CAUSE_SOURCE;
        end else if (escape_pending_reg && decode_hit) begin
            escape_pending_next  = 1'b0;
            result_hit           = 1'b1;
            result_next.out_byte = decoded;
            result_next.has_byte = 1'b1;
        end else if (!escape_pending_reg && escapes_enabled_reg && c == CH_BACKSLASH) begin
            escape_pending_next = 1'b1;
        end else begin
            escape_pending_next = 1'b0;
            if (line_delim && is_line) begin
                result_hit             = 1'b1;
                result_next.token_last = 1'b1;
                result_next.end_cause  = CAUSE_LINE_END;
            end else if (c == delimiter_reg) begin
                result_hit             = 1'b1;
                result_next.token_last = 1'b1;
                result_next.end_cause  = CAUSE_DELIMITER;
            end else if (c >= CH_SPACE || is_line) begin
                result_hit           = 1'b1;
                result_next.out_byte = plain_byte;
                result_next.has_byte = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delimiter_reg       <= DELIMITER_RESET;
            escapes_enabled_reg <= ESCAPES_RESET;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_DELIMITER: delimiter_reg       <= pwdata[7:0];
                REG_ESCAPES:   escapes_enabled_reg <= pwdata[0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            escape_pending_reg <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            if (in_accept) begin
                escape_pending_reg <= escape_pending_next;
                m_valid_reg        <= result_hit;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept && result_hit) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = result_reg.out_byte;
    assign m_tlast  = result_reg.token_last;
    assign m_tuser  = {result_reg.end_cause, result_reg.has_byte};

endmodule

`default_nettype wire

// File: tb/sv/dts_token_check.sv
// Checker for the delimited token scanner: watches the input, result and APB channels,
// predicts each result from its own copy of the scanner state and compares it field by field.
// Depends on dts_pkg for the byte constants, the end cause codes and the register indexes.
`timescale 1ns / 1ps

module dts_token_check
    import dts_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire  [7:0]  s_tdata,
    input  wire  [0:0]  s_tuser,
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire  [7:0]  m_tdata,
    input  wire         m_tlast,
    input  wire  [2:0]  m_tuser,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    input  wire         pready,
    output int          fail_count,
    output int          outstanding
);

    logic [7:0] delim_q;
    logic       esc_en_q;
    logic       esc_pend_q;
    result_t    token_q[$];

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 40) begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
    endtask

    function automatic bit classify_plain(input logic [7:0] c, output result_t r);
        r = '0;
        if ((delim_q == CH_LF || delim_q == CH_SPACE) && (c == CH_LF || c == CH_CR)) begin
            r.token_last = 1'b1;
            r.end_cause  = CAUSE_LINE_END;
            return 1'b1;
        end
        if (c == delim_q) begin
            r.token_last = 1'b1;
            r.end_cause  = CAUSE_DELIMITER;
            return 1'b1;
        end
        if (c >= CH_SPACE || c == CH_LF || c == CH_CR) begin
            r.out_byte = c;
            r.has_byte = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit scan_item(input logic [7:0] c, input logic se, output result_t r);
        r = '0;
        if (se) begin
            esc_pend_q   = 1'b0;
            r.token_last = 1'b1;
            r.end_cause  = CAUSE_SOURCE;
            return 1'b1;
        end
        if (esc_pend_q) begin
            esc_pend_q = 1'b0;
            r.has_byte = 1'b1;
            case (c)
                CH_N:     r.out_byte = CH_LF;
                CH_R:     r.out_byte = CH_CR;
                CH_QUOTE: r.out_byte = CH_QUOTE;
                CH_CARET: r.out_byte = CH_ESC;
                default:  return classify_plain(c, r);
            endcase
            return 1'b1;
        end
        if (c == CH_BACKSLASH && esc_en_q) begin
            esc_pend_q = 1'b1;
            return 1'b0;
        end
        return classify_plain(c, r);
    endfunction

    always @(posedge aclk) begin : track
        result_t got;
        result_t want;
        result_t next_res;
        if (!aresetn) begin
            delim_q    = DELIMITER_RESET;
            esc_en_q   = ESCAPES_RESET;
            esc_pend_q = 1'b0;
            fail_count = 0;
            token_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.out_byte   = m_tdata;
                got.has_byte   = m_tuser[0];
                got.token_last = m_tlast;
                got.end_cause  = end_cause_t'(m_tuser[2:1]);
                if (token_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected item byte %02h has %0d last %0d cause %0d",
                        got.out_byte, got.has_byte, got.token_last, got.end_cause));
                end else begin
                    want = token_q.pop_front();
                    if (got.out_byte !== want.out_byte) begin
                        report_mismatch($sformatf("out_byte got %02h want %02h",
                            got.out_byte, want.out_byte));
                    end
                    if (got.has_byte !== want.has_byte) begin
                        report_mismatch($sformatf("has_byte got %0d want %0d",
                            got.has_byte, want.has_byte));
                    end
                    if (got.token_last !== want.token_last) begin
                        report_mismatch($sformatf("token_last got %0d want %0d",
                            got.token_last, want.token_last));
                    end
                    if (got.end_cause !== want.end_cause) begin
                        report_mismatch($sformatf("end_cause got %0d want %0d",
                            got.end_cause, want.end_cause));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (scan_item(s_tdata, s_tuser[0], next_res)) begin
                    token_q.push_back(next_res);
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (reg_index_t'(paddr[2]))
                    REG_DELIMITER: delim_q  = pwdata[7:0];
                    REG_ESCAPES:   esc_en_q = pwdata[0];
                    default: ;
                endcase
            end
        end
        outstanding <= token_q.size();
    end

endmodule

// File: tb/sv/testbench.sv
// Top of the delimited token scanner testbench: clock, reset, APB register writes, byte stream
// stimulus with random idling on both channels, watchdog and verdict.
// Depends on dts_pkg, delimited_token_scanner_top and dts_token_check.
`timescale 1ns / 1ps

module testbench;
    import dts_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic [0:0]  s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [2:0]  m_tuser;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = 3'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int outstanding;
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int idle_cycles     = 0;

    logic [7:0] cur_delim = DELIMITER_RESET;

    delimited_token_scanner_top u_dut (.*);

    dts_token_check u_check (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_item(input logic [7:0] b, input logic se);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= se;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Stops the sender and waits until every predicted result has been taken, then lets
    // the last item settle before anything else happens.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [7:0] value);
        logic [31:0] word;
        word = $urandom();
        case (idx)
            REG_DELIMITER: word[7:0] = value;
            REG_ESCAPES:   word[0]   = value[0];
            default: ;
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        if (idx == REG_DELIMITER) begin
            cur_delim = value;
        end
    endtask

    task automatic set_config(input logic [7:0] delim, input logic esc_en);
        write_reg(REG_DELIMITER, delim);
        write_reg(REG_ESCAPES, {7'd0, esc_en});
    endtask

    initial begin : stimulus
        int         phase;
        int         k;
        int         pick;
        logic [7:0] b;
        logic       se;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset defaults: space delimiter, escapes on.
        send_item(8'h41, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(CH_SPACE, 1'b0);
        send_item(CH_LF, 1'b0);
        send_item(CH_CR, 1'b0);
        send_item(CH_BACKSLASH, 1'b0);
        send_item(CH_N, 1'b0);
        send_item(CH_BACKSLASH, 1'b0);
        send_item(CH_R, 1'b0);
        send_item(CH_BACKSLASH, 1'b0);
        send_item(CH_QUOTE, 1'b0);
        send_item(CH_BACKSLASH, 1'b0);
        send_item(CH_CARET, 1'b0);
        send_item(CH_BACKSLASH, 1'b0);
        send_item(8'h78, 1'b0);
        send_item(CH_BACKSLASH, 1'b0);
        send_item(CH_BACKSLASH, 1'b0);
        send_item(CH_BACKSLASH, 1'b0);
        send_item(8'hFF, 1'b1);
        send_item(8'h00, 1'b1);

        // A pending escape survives a register write and is still decoded.
        send_item(CH_BACKSLASH, 1'b0);
        drain_results();
        write_reg(REG_ESCAPES, 8'd0);
        send_item(CH_N, 1'b0);
        send_item(CH_BACKSLASH, 1'b0);

        // A second backslash is ordinary and can end the token.
        drain_results();
        set_config(CH_BACKSLASH, 1'b1);
        send_item(CH_BACKSLASH, 1'b0);
        send_item(CH_BACKSLASH, 1'b0);

        // A decoded quote never ends the token, even as the delimiter.
        drain_results();
        write_reg(REG_DELIMITER, CH_QUOTE);
        send_item(CH_BACKSLASH, 1'b0);
        send_item(CH_QUOTE, 1'b0);
        send_item(CH_QUOTE, 1'b0);

        for (phase = 0; phase < 8; phase++) begin
            drain_results();
            case (phase)
                0: set_config(CH_SPACE, 1'b1);
                1: set_config(CH_LF, 1'b0);
                2: set_config(8'd0, 1'b1);
                3: set_config(8'd255, 1'b1);
                4: set_config(CH_BACKSLASH, 1'b1);
                5: set_config(CH_CR, 1'b0);
                6: set_config(8'($urandom_range(255)), 1'($urandom_range(1)));
                default: set_config(CH_QUOTE, 1'b1);
            endcase
            case (phase % 4)
                0: begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                end
                1: begin
                    sender_idle_pct = 58;
                    recv_stall_pct  = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 58;
                end
                default: begin
                    sender_idle_pct = 16;
                    recv_stall_pct  = 16;
                end
            endcase
            for (k = 0; k < 128; k++) begin
                if (phase == 2 && k == 64) begin
                    drain_results();
                end
                pick = $urandom_range(99);
                se   = 1'b0;
                if (pick < 30) begin
                    b = 8'($urandom_range(8'h7E, 8'h21));
                end else if (pick < 45) begin
                    b = CH_BACKSLASH;
                end else if (pick < 55) begin
                    case ($urandom_range(3))
                        0: b = CH_N;
                        1: b = CH_R;
                        2: b = CH_QUOTE;
                        default: b = CH_CARET;
                    endcase
                end else if (pick < 65) begin
                    b = cur_delim;
                end else if (pick < 70) begin
                    b = $urandom_range(1) ? CH_LF : CH_CR;
                end else if (pick < 74) begin
                    b  = 8'($urandom());
                    se = 1'b1;
                end else begin
                    b  = 8'($urandom());
                    se = ($urandom_range(15) == 0);
                end
                send_item(b, se);
            end
        end

        drain_results();
        repeat (5) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
